>>> rtl/mms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mms_pkg;

  // Width of the internal time stamps; now_ms is cut or zero-extended to it.
  localparam int TIME_W = 32;
  localparam int TIMEOUT_W = 32;
  localparam int CMP_W = (TIME_W > TIMEOUT_W) ? TIME_W : TIMEOUT_W;

  localparam int ALT_THR_W = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [TIMEOUT_W-1:0] timeout_t;

  localparam logic [1:0] KIND_UPDATE   = 2'd0;
  localparam logic [1:0] KIND_TAKEOFF  = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_TAKEOFF  = 3'd1;
  localparam logic [2:0] MODE_LINE     = 3'd2;
  localparam logic [2:0] MODE_APPROACH = 3'd3;
  localparam logic [2:0] MODE_HOVER    = 3'd4;
  localparam logic [2:0] MODE_LAND     = 3'd5;
  localparam logic [2:0] MODE_COMPLETE = 3'd6;
  localparam logic [2:0] MODE_ABORT    = 3'd7;

  localparam logic [2:0] RSN_NONE       = 3'd0;
  localparam logic [2:0] RSN_ABORT      = 3'd1;
  localparam logic [2:0] RSN_SAFETY     = 3'd2;
  localparam logic [2:0] RSN_LINE_END   = 3'd3;
  localparam logic [2:0] RSN_DURATION   = 3'd4;
  localparam logic [2:0] RSN_APPR_TMO   = 3'd5;
  localparam logic [2:0] RSN_LOST       = 3'd6;
  localparam logic [2:0] RSN_HOVER_DONE = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_ALT_THR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LOST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_DUR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_APPR_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_LOST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOVER       = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic               abort_req;
    logic               land_req;
    logic               marker_vis;
    logic               marker_ctr;
    logic               line_vis;
    logic               alt_valid;
    logic signed [15:0] altitude_cm;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] landing_reason;
  } out_item_t;

  typedef struct packed {
    logic [ALT_THR_W-1:0] altitude_threshold_cm;
    timeout_t             line_lost_timeout_ms;
    timeout_t             line_follow_duration_ms;
    timeout_t             marker_approach_timeout_ms;
    timeout_t             marker_lost_timeout_ms;
    timeout_t             marker_hover_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0] mode;
    stamp_t     mode_entered_time;
    stamp_t     line_seen_time;
    stamp_t     marker_seen_time;
    logic [2:0] reason_code;
  } seq_state_t;

  // True when the wrapping time since then has reached the limit.
  function automatic logic elapsed_ge(stamp_t now, stamp_t then, timeout_t limit);
    stamp_t diff;
    diff = now - then;
    return CMP_W'(diff) >= CMP_W'(limit);
  endfunction

endpackage

`default_nettype wire

>>> rtl/mms_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module mms_cfg
  import mms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_regs_t                  regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_ALT_THR:     regs_nxt.altitude_threshold_cm = wr_data[ALT_THR_W-1:0];
        REG_LINE_LOST:   regs_nxt.line_lost_timeout_ms = TIMEOUT_W'(wr_data);
        REG_LINE_DUR:    regs_nxt.line_follow_duration_ms = TIMEOUT_W'(wr_data);
        REG_APPR_TMO:    regs_nxt.marker_approach_timeout_ms = TIMEOUT_W'(wr_data);
        REG_MARKER_LOST: regs_nxt.marker_lost_timeout_ms = TIMEOUT_W'(wr_data);
        REG_HOVER:       regs_nxt.marker_hover_ms = TIMEOUT_W'(wr_data);
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

>>> rtl/mms_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mms_step
  import mms_pkg::*;
(
  input  wire in_item_t   item,
  input  wire cfg_regs_t  cfg,
  input  wire seq_state_t cur,
  output seq_state_t      nxt
);

  stamp_t now;
  logic   mk;
  logic   ln;
  logic   ctr;
  logic   land;

  assign now  = TIME_W'(item.now_ms);
  assign mk   = item.marker_vis;
  assign ln   = item.line_vis;
  assign ctr  = item.marker_ctr;
  assign land = item.land_req;

  // The mode checks run in order so that a transition falls through to the
  // checks of the newly entered mode within the same item.
  always_comb begin
    seq_state_t s;
    s = cur;
    case (item.kind)
      KIND_UPDATE: begin
        if (item.abort_req) begin
          s.reason_code = RSN_ABORT;
          s.mode = MODE_ABORT;
        end else begin
          if (mk) begin
            s.marker_seen_time = now;
          end

          if (s.mode == MODE_TAKEOFF && item.alt_valid &&
              item.altitude_cm >= $signed({1'b0, cfg.altitude_threshold_cm})) begin
            s.mode = MODE_LINE;
            s.mode_entered_time = now;
            s.line_seen_time = now;
          end

          if (s.mode == MODE_LINE) begin
            if (ln) begin
              s.line_seen_time = now;
            end
            if (land) begin
              s.reason_code = RSN_SAFETY;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end else if (mk) begin
              s.mode = MODE_APPROACH;
              s.mode_entered_time = now;
            end else if (!ln &&
                         elapsed_ge(now, s.line_seen_time, cfg.line_lost_timeout_ms)) begin
              s.reason_code = RSN_LINE_END;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end else if (elapsed_ge(now, s.mode_entered_time,
                                    cfg.line_follow_duration_ms)) begin
              s.reason_code = RSN_DURATION;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end
          end

          if (s.mode == MODE_APPROACH) begin
            if (land) begin
              s.reason_code = RSN_SAFETY;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end else if (ctr) begin
              s.mode = MODE_HOVER;
              s.mode_entered_time = now;
            end else if (!mk && !ln && elapsed_ge(now, s.mode_entered_time,
                                                  cfg.marker_approach_timeout_ms)) begin
              s.reason_code = RSN_APPR_TMO;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end else if (!mk && !ln && elapsed_ge(now, s.marker_seen_time,
                                                  cfg.marker_lost_timeout_ms)) begin
              s.reason_code = RSN_LOST;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end
          end

          if (s.mode == MODE_HOVER) begin
            if (land) begin
              s.reason_code = RSN_SAFETY;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end else if (!mk && ln) begin
              s.mode = MODE_APPROACH;
              s.mode_entered_time = now;
            end else if (!mk && !ln && elapsed_ge(now, s.marker_seen_time,
                                                  cfg.marker_lost_timeout_ms)) begin
              s.reason_code = RSN_LOST;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end else if (mk && !ctr) begin
              s.mode = MODE_APPROACH;
              s.mode_entered_time = now;
            end else if (elapsed_ge(now, s.mode_entered_time, cfg.marker_hover_ms)) begin
              s.reason_code = RSN_HOVER_DONE;
              s.mode = MODE_LAND;
              s.mode_entered_time = now;
            end
          end
        end
      end
      KIND_TAKEOFF: begin
        s.mode = MODE_TAKEOFF;
        s.mode_entered_time = now;
        s.line_seen_time = now;
      end
      KIND_COMPLETE: begin
        s.mode = MODE_COMPLETE;
      end
      default: begin
        s = cur;
      end
    endcase
    nxt = s;
  end

endmodule

`default_nettype wire

>>> rtl/mission_mode_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Mission mode sequencer. Every item, update observation or command, yields
// exactly one result item carrying the mode after the item and the current
// landing reason. Items are taken into an input register, evaluated
// combinationally against the mode state and configuration registers, and the
// result is held in an output register until taken; one item per cycle is
// sustained while the output is not stalled, and each result passes through
// the input and output registers. The rate is set by the state update, a
// combinational chain of at most four mode checks (takeoff, line follow,
// approach, hover), each with up to two 32-bit wrapping subtract-and-compare
// paths. Configuration registers take writes in any cycle (cfg_ready is
// always high) and must only be written while no item is in flight.
module mission_mode_sequencer_top
  import mms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t  cfg;
  in_item_t   item_r;
  logic       item_valid_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_item_t  out_data_r;
  logic       out_valid_r;
  logic       advance;

  assign cfg_ready = 1'b1;

  mms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  mms_step u_step (
    .item (item_r),
    .cfg  (cfg),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.mode           <= state_nxt.mode;
      out_data_r.landing_reason <= state_nxt.reason_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
